// ----- rtl/core/rmd_pkg.sv -----
// Shared types and constants for the reflective mark detector.
`default_nettype none
package rmd_pkg;
	localparam int unsigned CFG_IDX_BITS = 3;
	localparam int unsigned CFG_DATA_BITS = 20;
	localparam logic [2:0] REG_DEPTH = 3'd0;
	localparam logic [2:0] REG_MIN_AREA = 3'd1;
	localparam logic [2:0] REG_MAX_AREA = 3'd2;
	localparam logic [2:0] REG_VOID = 3'd3;
	localparam logic [2:0] REG_ALPHA = 3'd4;
	localparam logic FUNC_SAMPLE = 1'b0;
	localparam logic FUNC_RESTART = 1'b1;

	// Control sent from the sequencer to every history cell.
	typedef struct packed {
		logic shift;
		logic rotate;
	} cell_ctrl_t;
endpackage
`default_nettype wire

// ----- rtl/core/reflective_mark_detector.sv -----
// Top level of the reflective mark detector: sequencer, averager and cell chain.
// A sample item passes the divider, the EMA update, a full rotation of the chain and the
// judge before its result is registered; a restart goes straight to the result registers.
// One item at a time; the next one is accepted only once the result is loaded and the sequencer is idle;
// the chain rotation dominates the time a sample item takes.
// Reset zeroes the cells, ring, ring pointer, sample count and outputs; the config registers get their reset values.
`default_nettype none
module reflective_mark_detector #(
	parameter int unsigned HISTORY_DEPTH = 250,
	parameter int unsigned AVERAGE_TAPS = 10,
	parameter int unsigned SAMPLE_BITS = 12
) (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        in_valid,
	output logic                       in_stall,
	input  wire                        func,
	input  wire  [SAMPLE_BITS-1:0]     sample,
	input  wire  signed [31:0]         feed_pos,
	output logic                       out_valid,
	input  wire                        out_stall,
	output logic                       mark_found,
	output logic signed [31:0]         mark_pos,
	output logic                       void_present,
	output logic                       void_absent,
	output logic                       window_filled,
	output logic [11:0]                filtered_value,
	input  wire                        cfg_valid,
	output logic                       cfg_ready,
	input  wire  [rmd_pkg::CFG_IDX_BITS-1:0]  cfg_index,
	input  wire  [rmd_pkg::CFG_DATA_BITS-1:0] cfg_data
);
	localparam int unsigned SUM_BITS = SAMPLE_BITS + $clog2(AVERAGE_TAPS + 1);
	localparam int unsigned TAP_BITS = $clog2(AVERAGE_TAPS + 1);
	localparam int unsigned PTR_BITS = (AVERAGE_TAPS > 1) ? $clog2(AVERAGE_TAPS) : 1;
	localparam int unsigned HCNT_BITS = $clog2(HISTORY_DEPTH + 1);
	localparam int unsigned CENTER = HISTORY_DEPTH / 2;
	localparam int unsigned MINV_BITS = SAMPLE_BITS + 1;
	localparam int unsigned AREA_BITS_L = SAMPLE_BITS + HCNT_BITS;

	typedef enum logic [2:0] {ST_IDLE, ST_DIV, ST_EMA, ST_SCAN, ST_JUDGE, ST_OUT} state_t;
	state_t state_q;

	// Configuration registers.
	logic [11:0] depth_q;
	logic [19:0] min_area_q, max_area_q;
	logic [11:0] void_q;
	logic [15:0] alpha_q;

	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q <= 12'd80;
			min_area_q <= 20'd4000;
			max_area_q <= 20'd20000;
			void_q <= 12'd120;
			alpha_q <= 16'd13107;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				rmd_pkg::REG_DEPTH:    depth_q <= cfg_data[11:0];
				rmd_pkg::REG_MIN_AREA: min_area_q <= cfg_data;
				rmd_pkg::REG_MAX_AREA: max_area_q <= cfg_data;
				rmd_pkg::REG_VOID:     void_q <= cfg_data[11:0];
				rmd_pkg::REG_ALPHA:    alpha_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// Moving-average ring.
	logic [SAMPLE_BITS-1:0] ring_q [AVERAGE_TAPS];
	logic [PTR_BITS-1:0] ptr_q;
	logic [SUM_BITS-1:0] sum_q;
	logic ring_full_q;

	// Item latches and working state.
	logic [SAMPLE_BITS-1:0] x_q;
	logic [31:0] pos_in_q;
	logic [SAMPLE_BITS-1:0] ltl_q;
	logic [HCNT_BITS-1:0] seen_q;
	logic filled_q;
	logic [31:0] last_mark_q;
	logic found_q;
	logic [HCNT_BITS-1:0] scan_q;
	logic [MINV_BITS-1:0] min_q;
	logic [HCNT_BITS-1:0] min_at_q;
	logic [31:0] min_pos_q;
	logic [AREA_BITS_L-1:0] area_q;
	logic [SAMPLE_BITS-1:0] tail_q;

	// Divider for the average.
	logic div_start, div_done;
	logic [SUM_BITS-1:0] div_quot;
	logic [TAP_BITS-1:0] div_den;
	logic [SUM_BITS-1:0] new_sum;
	logic [SAMPLE_BITS-1:0] x_cur;
	logic [PTR_BITS:0] next_p;
	logic wraps;

	// Cell chain; cell 0 is the newest entry.
	rmd_pkg::cell_ctrl_t ctrl;
	logic [SAMPLE_BITS-1:0] lvl [HISTORY_DEPTH];
	logic [31:0] pos [HISTORY_DEPTH];
	genvar g;
	generate
		for (g = 0; g < HISTORY_DEPTH; g++) begin : g_cell
			logic [SAMPLE_BITS-1:0] lin;
			logic [31:0] pin;
			if (g == 0) begin : g_head
				assign lin = ctrl.rotate ? lvl[HISTORY_DEPTH-1] : div_quot[SAMPLE_BITS-1:0];
				assign pin = ctrl.rotate ? pos[HISTORY_DEPTH-1] : pos_in_q;
			end else begin : g_body
				assign lin = lvl[g-1];
				assign pin = pos[g-1];
			end
			rmd_cell #(.SAMPLE_BITS(SAMPLE_BITS)) u_cell (
				.clk(clk), .arst_n(arst_n), .ctrl(ctrl),
				.level_in(lin), .pos_in(pin), .level_q(lvl[g]), .pos_q(pos[g])
			);
		end
	endgenerate

	// The divider takes its numerator at the accepting edge, before x_q holds the sample.
	assign x_cur = (state_q == ST_IDLE) ? sample : x_q;
	assign new_sum = sum_q - SUM_BITS'(ring_q[ptr_q]) + SUM_BITS'(x_cur);
	assign next_p = {1'b0, ptr_q} + 1'b1;
	assign wraps = next_p >= (PTR_BITS+1)'(AVERAGE_TAPS);
	assign div_den = (ring_full_q || wraps) ? TAP_BITS'(AVERAGE_TAPS) : TAP_BITS'(next_p);
	rmd_divider #(.NUM_BITS(SUM_BITS), .DEN_BITS(TAP_BITS)) u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .num(new_sum), .den(div_den),
		.done(div_done), .quot(div_quot)
	);

	// EMA product terms, combinational; the blended level is registered into ltl_q.
	logic [SAMPLE_BITS+16:0] ema_acc;
	assign ema_acc = (SAMPLE_BITS+17)'(alpha_q) * (SAMPLE_BITS+17)'(x_q)
		+ (SAMPLE_BITS+17)'(17'h10000 - 17'(alpha_q)) * (SAMPLE_BITS+17)'(ltl_q);

	logic [SAMPLE_BITS:0] tol;
	logic tol_ok;
	assign tol_ok = {1'b0, ltl_q} >= (SAMPLE_BITS+1)'(depth_q);
	assign tol = {1'b0, ltl_q} - (SAMPLE_BITS+1)'(depth_q);
	logic [SAMPLE_BITS:0] cur;
	assign cur = {1'b0, lvl[HISTORY_DEPTH-1]};

	// The result registers let a finished item wait without holding up the next one.
	logic out_load;
	assign out_load = (state_q == ST_OUT) && (!out_valid || !out_stall);

	assign in_stall = (state_q != ST_IDLE);
	assign div_start = (state_q == ST_IDLE) && in_valid && !in_stall
		&& (func == rmd_pkg::FUNC_SAMPLE);
	always_comb begin
		ctrl.shift = (state_q == ST_DIV) && div_done;
		ctrl.rotate = (state_q == ST_SCAN);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			for (int i = 0; i < AVERAGE_TAPS; i++) ring_q[i] <= '0;
			ptr_q <= '0;
			sum_q <= '0;
			ring_full_q <= 1'b0;
			ltl_q <= '0;
			seen_q <= '0;
			filled_q <= 1'b0;
			last_mark_q <= '0;
			found_q <= 1'b0;
			out_valid <= 1'b0;
			mark_found <= 1'b0;
			mark_pos <= '0;
			void_present <= 1'b0;
			void_absent <= 1'b0;
			window_filled <= 1'b0;
			filtered_value <= '0;
		end else begin
			if (out_load) begin
				out_valid <= 1'b1;
				mark_found <= found_q;
				mark_pos <= last_mark_q;
				void_present <= {4'b0, lvl[0]} < {4'b0, void_q};
				void_absent <= {4'b0, lvl[0]} > {4'b0, void_q};
				window_filled <= filled_q;
				filtered_value <= 12'(lvl[0]);
			end else if (out_valid && !out_stall) begin
				out_valid <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid && !in_stall) begin
						if (func == rmd_pkg::FUNC_RESTART) begin
							seen_q <= '0;
							filled_q <= 1'b0;
							ltl_q <= '0;
							found_q <= 1'b0;
							state_q <= ST_OUT;
						end else begin
							x_q <= sample;
							pos_in_q <= feed_pos;
							state_q <= ST_DIV;
						end
					end
				end
				ST_DIV: begin
					if (div_done) begin
						sum_q <= new_sum;
						ring_q[ptr_q] <= x_q;
						ptr_q <= wraps ? '0 : next_p[PTR_BITS-1:0];
						if (wraps) ring_full_q <= 1'b1;
						state_q <= ST_EMA;
					end
				end
				ST_EMA: begin
					ltl_q <= (ltl_q == '0) ? x_q : ema_acc[SAMPLE_BITS+15:16];
					if (!filled_q) begin
						seen_q <= seen_q + 1'b1;
						if (seen_q + 1'b1 >= HCNT_BITS'(HISTORY_DEPTH)) filled_q <= 1'b1;
					end
					scan_q <= HCNT_BITS'(HISTORY_DEPTH - 1);
					min_q <= MINV_BITS'(1 << SAMPLE_BITS);
					area_q <= '0;
					tail_q <= lvl[HISTORY_DEPTH-1];
					state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					// The chain rotates; the tail cell shows entry scan_q.
					if (cur < {1'b0, min_q[SAMPLE_BITS-1:0]} || min_q[SAMPLE_BITS]) begin
						if (cur <= {1'b0, min_q[SAMPLE_BITS-1:0]} || min_q[SAMPLE_BITS]) begin
							min_q <= MINV_BITS'(cur);
							min_at_q <= scan_q;
							min_pos_q <= pos[HISTORY_DEPTH-1];
						end
					end else if (cur == {1'b0, min_q[SAMPLE_BITS-1:0]}) begin
						min_at_q <= scan_q;
						min_pos_q <= pos[HISTORY_DEPTH-1];
					end
					if (tol_ok && cur < tol)
						area_q <= area_q + AREA_BITS_L'(tol - cur);
					scan_q <= scan_q - 1'b1;
					if (scan_q == '0) state_q <= ST_JUDGE;
				end
				ST_JUDGE: begin
					if (min_at_q == HCNT_BITS'(CENTER) && tol_ok
						&& {1'b0, min_q[SAMPLE_BITS-1:0]} <= tol
						&& {1'b0, lvl[0]} >= tol && {1'b0, tail_q} >= tol
						&& area_q >= AREA_BITS_L'(min_area_q)
						&& area_q <= AREA_BITS_L'(max_area_q)) begin
						found_q <= 1'b1;
						last_mark_q <= min_pos_q;
					end else begin
						found_q <= 1'b0;
					end
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (out_load) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> in_stall) else $error("accept while busy");
	a_scan_rotate: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.shift |-> !ctrl.rotate) else $error("shift and rotate together");
	a_out_after: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_OUT) |=> out_valid) else $error("result not shown");
endmodule
`default_nettype wire

// ----- rtl/core/rmd_cell.sv -----
// One history cell: holds a level and a position and hands them to its neighbor.
`default_nettype none
module rmd_cell #(
	parameter int unsigned SAMPLE_BITS = 12
) (
	input  wire                      clk,
	input  wire                      arst_n,
	input  rmd_pkg::cell_ctrl_t      ctrl,
	input  wire  [SAMPLE_BITS-1:0]   level_in,
	input  wire  [31:0]              pos_in,
	output logic [SAMPLE_BITS-1:0]   level_q,
	output logic [31:0]              pos_q
);
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q <= '0;
			pos_q <= '0;
		end else if (ctrl.shift || ctrl.rotate) begin
			level_q <= level_in;
			pos_q <= pos_in;
		end
	end
endmodule
`default_nettype wire

// ----- rtl/core/rmd_divider.sv -----
// Restoring divider for the moving-average sum, one quotient bit per cycle.
`default_nettype none
module rmd_divider #(
	parameter int unsigned NUM_BITS = 16,
	parameter int unsigned DEN_BITS = 5
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 start,
	input  wire  [NUM_BITS-1:0] num,
	input  wire  [DEN_BITS-1:0] den,
	output logic                done,
	output logic [NUM_BITS-1:0] quot
);
	localparam int unsigned CNT_BITS = $clog2(NUM_BITS + 1);
	logic [CNT_BITS-1:0] cnt_q;
	logic busy_q;
	logic [NUM_BITS-1:0] num_q;
	logic [DEN_BITS-1:0] den_q;
	logic [DEN_BITS:0] rem_q;
	logic [DEN_BITS:0] trial;

	assign trial = {rem_q[DEN_BITS-1:0], num_q[NUM_BITS-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done <= 1'b0;
			cnt_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= CNT_BITS'(NUM_BITS);
				num_q <= num;
				den_q <= den;
				rem_q <= '0;
				quot <= '0;
			end else if (busy_q) begin
				num_q <= num_q << 1;
				if (trial >= {1'b0, den_q}) begin
					rem_q <= trial - {1'b0, den_q};
					quot <= {quot[NUM_BITS-2:0], 1'b1};
				end else begin
					rem_q <= trial;
					quot <= {quot[NUM_BITS-2:0], 1'b0};
				end
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_BITS'(1)) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end
endmodule
`default_nettype wire
